FILE: hw/rtl/mrpq_pkg.sv
// types and constants shared by the monotone radix priority queue
`default_nettype none
package mrpq_pkg;

    localparam int unsigned ID_W   = 10;
    localparam int unsigned COST_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DECREASE = 2'd1,
        MODE_EXTRACT  = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BELOW = 2'd2,
        STAT_BADID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_TAIL,
        ST_DELETE,
        ST_WIPE,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic del;
        logic wipe;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic addr_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/mrpq_in_if.sv
// request channel interface
`default_nettype none
interface mrpq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [9:0]  node_id;
    logic [31:0] new_cost;

    modport source (output valid, output mode, output node_id, output new_cost, input ready);
    modport sink (input valid, input mode, input node_id, input new_cost, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mrpq_out_if.sv
// result channel interface
`default_nettype none
interface mrpq_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_id;
    logic [31:0] out_cost;
    logic [1:0]  status;
    logic        not_empty;

    modport source (output valid, output out_id, output out_cost, output status,
                    output not_empty, input ready);
    modport sink (input valid, input out_id, input out_cost, input status,
                  input not_empty, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/monotone_radix_priority_queue.sv
// top level of the monotone radix priority queue
`default_nettype none
// Monotone priority queue over CAPACITY entry ids with costs of COST_BITS
// bits. Each request beat carries insert, decrease key, extract minimum or
// clear, and produces exactly one result beat. One request is in work at a
// time; a finished result waits in an output register, and the next request
// is taken while it waits. Extract minimum searches the entry table, which
// sits in one RAM with a single read port, and the search walks all
// CAPACITY entries one per cycle. An extract on an empty queue skips the
// search. Clear runs a pass that zeroes the present flag of every entry,
// and after reset the same pass runs before the first request is accepted.
// The search looks for the least cost, lowest id on ties.
module monotone_radix_priority_queue #(
    parameter int unsigned CAPACITY  = 1024,
    parameter int unsigned COST_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrpq_in_if.sink    i_req,
    mrpq_out_if.source o_rsp
);
    mrpq_pkg::t_cmd w_cmd;
    mrpq_pkg::t_sts w_sts;

    // operation sequencer
    mrpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_mode  (i_req.mode),
        .i_sts   (w_sts),
        .o_ready (i_req.ready),
        .o_cmd   (w_cmd)
    );

    // entry table, search and result register
    mrpq_dp #(
        .CAPACITY  (CAPACITY),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (i_req.mode),
        .i_node_id   (i_req.node_id),
        .i_new_cost  (i_req.new_cost),
        .i_out_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_rsp.valid),
        .o_out_id    (o_rsp.out_id),
        .o_out_cost  (o_rsp.out_cost),
        .o_status    (o_rsp.status),
        .o_not_empty (o_rsp.not_empty)
    );

    // the sequencer drives at most one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.check, w_cmd.scan, w_cmd.del, w_cmd.wipe, w_cmd.emit}))
        else $error("more than one datapath command");

    // a search only runs while entries exist
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |-> !w_sts.count_zero)
        else $error("search on empty queue");

    // an empty answer never claims remaining entries
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == mrpq_pkg::STAT_EMPTY) |-> !o_rsp.not_empty)
        else $error("empty status with entries left");

    // a result beat is only loaded when the output slot is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result overwrite");
endmodule
`default_nettype wire

FILE: hw/rtl/mrpq_ram.sv
// generic single write port ram with registered read
`default_nettype none
module mrpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/mrpq_ctrl.sv
// sequencer for the priority queue operations
`default_nettype none
module mrpq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [1:0]      i_mode,
    input  wire mrpq_pkg::t_sts  i_sts,
    output logic                 o_ready,
    output mrpq_pkg::t_cmd       o_cmd
);
    mrpq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrpq_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrpq_pkg::ST_INIT: begin
                if (i_sts.addr_last) n_state = mrpq_pkg::ST_IDLE;
            end
            mrpq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (mrpq_pkg::t_mode'(i_mode))
                        mrpq_pkg::MODE_INSERT,
                        mrpq_pkg::MODE_DECREASE: n_state = mrpq_pkg::ST_CHECK;
                        mrpq_pkg::MODE_EXTRACT:
                            n_state = i_sts.count_zero ? mrpq_pkg::ST_DONE
                                                       : mrpq_pkg::ST_SCAN;
                        mrpq_pkg::MODE_CLEAR:    n_state = mrpq_pkg::ST_WIPE;
                        default:                 n_state = mrpq_pkg::ST_DONE;
                    endcase
                end
            end
            mrpq_pkg::ST_CHECK:  n_state = mrpq_pkg::ST_DONE;
            mrpq_pkg::ST_SCAN: begin
                if (i_sts.addr_last) n_state = mrpq_pkg::ST_TAIL;
            end
            mrpq_pkg::ST_TAIL:   n_state = mrpq_pkg::ST_DELETE;
            mrpq_pkg::ST_DELETE: n_state = mrpq_pkg::ST_DONE;
            mrpq_pkg::ST_WIPE: begin
                if (i_sts.addr_last) n_state = mrpq_pkg::ST_DONE;
            end
            mrpq_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = mrpq_pkg::ST_IDLE;
            end
            default: n_state = mrpq_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            mrpq_pkg::ST_INIT:   o_cmd.wipe = 1'b1;
            mrpq_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            mrpq_pkg::ST_CHECK:  o_cmd.check = 1'b1;
            mrpq_pkg::ST_SCAN:   o_cmd.scan = 1'b1;
            mrpq_pkg::ST_TAIL:   o_cmd = '0;
            mrpq_pkg::ST_DELETE: o_cmd.del = 1'b1;
            mrpq_pkg::ST_WIPE:   o_cmd.wipe = 1'b1;
            mrpq_pkg::ST_DONE:   o_cmd.emit = i_sts.out_free;
            default:             o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/mrpq_dp.sv
// entry table, minimum search and result register
`default_nettype none
module mrpq_dp #(
    parameter int unsigned CAPACITY  = 1024,
    parameter int unsigned COST_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mrpq_pkg::t_cmd              i_cmd,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [mrpq_pkg::ID_W-1:0]   i_node_id,
    input  wire logic [mrpq_pkg::COST_W-1:0] i_new_cost,
    input  wire logic                        i_out_ready,
    output mrpq_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    output logic [mrpq_pkg::ID_W-1:0]        o_out_id,
    output logic [mrpq_pkg::COST_W-1:0]      o_out_cost,
    output logic [1:0]                       o_status,
    output logic                             o_not_empty
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = COST_BITS + 1;

    logic [AW-1:0]        r_addr;
    logic [CW-1:0]        r_count;
    logic [COST_BITS-1:0] r_last;
    mrpq_pkg::t_mode      r_mode;
    logic [mrpq_pkg::ID_W-1:0] r_id;
    logic [COST_BITS-1:0] r_cost;
    logic                 r_cmp_vld;
    logic [AW-1:0]        r_cmp_id;
    logic                 r_found;
    logic [AW-1:0]        r_best_id;
    logic [COST_BITS-1:0] r_best_cost;
    logic [mrpq_pkg::ID_W-1:0] r_res_id;
    logic [COST_BITS-1:0] r_res_cost;
    mrpq_pkg::t_status    r_res_status;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [DW-1:0]        wdata;
    logic [AW-1:0]        raddr;
    logic [DW-1:0]        rdata;
    logic                 rd_present;
    logic [COST_BITS-1:0] rd_cost;
    logic                 id_bad;
    mrpq_pkg::t_status    chk_status;
    logic                 better;

    assign rd_present = rdata[DW-1];
    assign rd_cost    = rdata[COST_BITS-1:0];
    assign raddr      = i_cmd.scan ? r_addr : AW'(i_node_id);

    assign id_bad = 32'(r_id) >= 32'(CAPACITY);

    always_comb begin
        priority if (id_bad || (rd_present != (r_mode == mrpq_pkg::MODE_DECREASE))) begin
            chk_status = mrpq_pkg::STAT_BADID;
        end else if (r_cost < r_last) begin
            chk_status = mrpq_pkg::STAT_BELOW;
        end else begin
            chk_status = mrpq_pkg::STAT_OK;
        end
    end

    // strict compare in ascending id order keeps the lowest id on ties
    assign better = rd_present && (!r_found || (rd_cost < r_best_cost));

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        priority if (i_cmd.wipe) begin
            we = 1'b1;
        end else if (i_cmd.check) begin
            we    = (chk_status == mrpq_pkg::STAT_OK);
            waddr = AW'(r_id);
            wdata = {1'b1, r_cost};
        end else if (i_cmd.del) begin
            we    = 1'b1;
            waddr = r_best_id;
        end
    end

    mrpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.scan || i_cmd.wipe) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                if (mrpq_pkg::t_mode'(i_mode) == mrpq_pkg::MODE_CLEAR) begin
                    r_count <= '0;
                    r_last  <= '0;
                end
            end
            if (r_cmp_vld && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.check && chk_status == mrpq_pkg::STAT_OK &&
                r_mode == mrpq_pkg::MODE_INSERT) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.del) begin
                r_count <= r_count - CW'(1);
                r_last  <= r_best_cost;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_id <= r_addr;
        if (i_cmd.load) begin
            r_mode     <= mrpq_pkg::t_mode'(i_mode);
            r_id       <= i_node_id;
            r_cost     <= COST_BITS'(i_new_cost);
            r_res_id   <= '0;
            r_res_cost <= '0;
            r_res_status <= (mrpq_pkg::t_mode'(i_mode) == mrpq_pkg::MODE_EXTRACT &&
                             r_count == '0) ? mrpq_pkg::STAT_EMPTY : mrpq_pkg::STAT_OK;
        end
        if (r_cmp_vld && better) begin
            r_best_id   <= r_cmp_id;
            r_best_cost <= rd_cost;
        end
        if (i_cmd.check) begin
            r_res_status <= chk_status;
        end
        if (i_cmd.del) begin
            r_res_id   <= mrpq_pkg::ID_W'(r_best_id);
            r_res_cost <= r_best_cost;
        end
        if (i_cmd.emit) begin
            o_out_id    <= r_res_id;
            o_out_cost  <= mrpq_pkg::COST_W'(r_res_cost);
            o_status    <= r_res_status;
            o_not_empty <= (r_count != '0);
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.addr_last  = (r_addr == AW'(CAPACITY - 1));
    assign o_sts.out_free   = !o_out_valid || i_out_ready;
endmodule
`default_nettype wire

FILE: bench/monotone_radix_priority_queue_test.sv
// testbench for the monotone radix priority queue: random and directed ops against a predictor
`default_nettype none
module monotone_radix_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_IDS = 1024;

    logic i_clk;
    logic i_rst_n;

    mrpq_in_if  req_ch ();
    mrpq_out_if rsp_ch ();

    monotone_radix_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    typedef struct packed {
        mrpq_pkg::t_mode mode;
        logic [9:0]      node_id;
        logic [31:0]     new_cost;
    } t_op;

    typedef struct packed {
        logic [9:0]        out_id;
        logic [31:0]       out_cost;
        mrpq_pkg::t_status status;
        logic              not_empty;
    } t_answer;

    // predictor state; cost and presence are enough, since the extracted
    // entry is always the least cost, lowest id on ties
    logic [31:0] pq_cost [NUM_IDS];
    bit          pq_here [NUM_IDS];
    logic [31:0] pq_floor;
    int          pq_count;

    t_op     pending_ops[$];
    t_answer answers_due[$];
    int      fail_count;
    bit      hold_sender;
    bit      no_idle;
    int      live_ids[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic t_answer predict_queue(input t_op op);
        t_answer a;
        int best;
        a = '0;
        a.status = mrpq_pkg::STAT_OK;
        case (op.mode)
            mrpq_pkg::MODE_INSERT, mrpq_pkg::MODE_DECREASE: begin
                if (pq_here[op.node_id] != (op.mode == mrpq_pkg::MODE_DECREASE)) begin
                    a.status = mrpq_pkg::STAT_BADID;
                end else if (op.new_cost < pq_floor) begin
                    a.status = mrpq_pkg::STAT_BELOW;
                end else begin
                    if (op.mode == mrpq_pkg::MODE_INSERT) begin
                        pq_here[op.node_id] = 1'b1;
                        pq_count++;
                    end
                    pq_cost[op.node_id] = op.new_cost;
                end
            end
            mrpq_pkg::MODE_EXTRACT: begin
                if (pq_count == 0) begin
                    a.status = mrpq_pkg::STAT_EMPTY;
                end else begin
                    best = -1;
                    for (int i = 0; i < NUM_IDS; i++)
                        if (pq_here[i] && (best < 0 || pq_cost[i] < pq_cost[best]))
                            best = i;
                    pq_here[best] = 1'b0;
                    pq_count--;
                    a.out_id   = best[9:0];
                    a.out_cost = pq_cost[best];
                    pq_floor   = pq_cost[best];
                end
            end
            default: begin
                for (int i = 0; i < NUM_IDS; i++) pq_here[i] = 1'b0;
                pq_count = 0;
                pq_floor = '0;
            end
        endcase
        a.not_empty = (pq_count > 0);
        return a;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: holds each beat until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() > 0 && !hold_sender
                && (no_idle || $urandom_range(99) >= 34)) begin
                t_op op;
                op = pending_ops.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.mode     <= op.mode;
                req_ch.node_id  <= op.node_id;
                req_ch.new_cost <= op.new_cost;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predictor runs once per accepted request beat, in beat order
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            answers_due.push_back(predict_queue(
                t_op'({req_ch.mode, req_ch.node_id, req_ch.new_cost})));
    end

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(rsp_ch.out_id), 64'd0);
                end else begin
                    t_answer w;
                    w = answers_due.pop_front();
                    if (rsp_ch.out_id !== w.out_id)
                        report_mismatch("out_id", 64'(rsp_ch.out_id), 64'(w.out_id));
                    if (rsp_ch.out_cost !== w.out_cost)
                        report_mismatch("out_cost", 64'(rsp_ch.out_cost), 64'(w.out_cost));
                    if (rsp_ch.status !== w.status)
                        report_mismatch("status", 64'(rsp_ch.status), 64'(w.status));
                    if (rsp_ch.not_empty !== w.not_empty)
                        report_mismatch("not_empty", 64'(rsp_ch.not_empty),
                                        64'(w.not_empty));
                end
            end
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    function automatic t_op make_op(input mrpq_pkg::t_mode m, input int id,
                                    input logic [31:0] c);
        t_op op;
        op.mode = m;
        op.node_id = id[9:0];
        op.new_cost = c;
        return op;
    endfunction

    // cost at or above the given floor: often near it, sometimes random or near the top
    function automatic logic [31:0] near_cost(input logic [31:0] fl);
        logic [31:0] c;
        case ($urandom_range(5))
            0: c = fl;
            1: c = fl + $urandom_range(3);
            2: c = fl + ($urandom() >> $urandom_range(31));
            3: c = $urandom();
            4: c = 32'hFFFF_FFFF - $urandom_range(2);
            default: c = fl + $urandom_range(255);
        endcase
        if (c < fl) c = fl;
        return c;
    endfunction

    task automatic drain_all();
        while (pending_ops.size() > 0 || req_ch.valid || answers_due.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] floor_guess;
        int id, k;
        fail_count  = 0;
        hold_sender = 1'b0;
        no_idle     = 1'b0;
        pq_floor    = '0;
        pq_count    = 0;
        for (int i = 0; i < NUM_IDS; i++) begin
            pq_here[i] = 1'b0;
            pq_cost[i] = '0;
        end
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = mrpq_pkg::MODE_INSERT;
        req_ch.node_id  = '0;
        req_ch.new_cost = '0;
        rsp_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty extract, extremes, ties, errors, decrease up, clear
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_DECREASE, 5, 1));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 1023, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 0, 7));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 700, 40));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 300, 40));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 512, 32'h8000_0000));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_DECREASE, 512, 32'h8000_0001));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 9, 3));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_DECREASE, 700, 2));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_DECREASE, 700, 41));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_CLEAR, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 1023, 0));
        pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT, 0, 0));
        drain_all();

        // sender held with a request pending, then released
        hold_sender = 1'b1;
        pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, 33, 100));
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        drain_all();

        // random: mostly well-formed inserts and decreases on a rising floor,
        // extracts rarer since they are slow, some broken requests, rare clears
        floor_guess = '0;
        for (int n = 0; n < 1500; n++) begin
            if (n == 600) no_idle = 1'b1;
            if (n == 800) no_idle = 1'b0;
            k = $urandom_range(99);
            if (k < 45) begin
                id = $urandom_range(1023);
                pending_ops.push_back(make_op(mrpq_pkg::MODE_INSERT, id,
                                              near_cost(floor_guess)));
                live_ids.push_back(id);
            end else if (k < 65 && live_ids.size() > 0) begin
                id = live_ids[$urandom_range(live_ids.size() - 1)];
                pending_ops.push_back(make_op(mrpq_pkg::MODE_DECREASE, id,
                                              near_cost(floor_guess)));
            end else if (k < 85) begin
                pending_ops.push_back(make_op(mrpq_pkg::MODE_EXTRACT,
                                              $urandom_range(1023), $urandom()));
                if ($urandom_range(1)) floor_guess = floor_guess + $urandom_range(63);
            end else if (k < 97) begin
                pending_ops.push_back(make_op(mrpq_pkg::t_mode'($urandom_range(1)),
                                              $urandom_range(1023), $urandom()));
            end else begin
                pending_ops.push_back(make_op(mrpq_pkg::MODE_CLEAR,
                                              $urandom_range(1023), $urandom()));
                floor_guess = '0;
                live_ids.delete();
            end
            if (pending_ops.size() > 8)
                while (pending_ops.size() > 2) @(posedge i_clk);
        end
        drain_all();
        repeat (2100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog: bounds the run of ~1520 ops, stalls included
    initial begin
        #(12ns * 10_000_000);
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
